@@ sv/whkr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// whkr_pkg
// Types and constants shared by the window path reorder block.
// ----------------------------------------------------------------------------
package whkr_pkg;
  localparam int MaxWindow = 10;
  localparam int StoreDepth = MaxWindow + 2;
  localparam int SetCount = 1 << MaxWindow;
  localparam int TableDepth = MaxWindow * SetCount;
  localparam int IdxW = 4;
  localparam int SetW = MaxWindow;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CostW = 31;
  localparam logic [CostW-1:0] CostInf = {CostW{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_SEED, ST_RD, ST_EDGE, ST_RDT, ST_WRT,
    ST_FIN_RD, ST_FIN_ED, ST_FIN_CMP, ST_BT_RD, ST_BT_WT, ST_OUT
  } state_t;

  typedef struct packed {
    logic             clear_acc;
    logic             do_init;
    logic             do_seed;
    logic             rd_src;
    logic             edge_go;
    logic             rd_dst;
    logic             wr_dst;
    logic             fin_rd;
    logic             fin_edge;
    logic             fin_cmp;
    logic             bt_rd;
    logic             bt_step;
    logic [IdxW-1:0]  j;
    logic [IdxW-1:0]  k;
    logic [SetW-1:0]  m;
    logic [SetW-1:0]  full;
    logic [IdxW-1:0]  n;
    logic [IdxW-1:0]  slot;
  } cmd_t;

  function automatic logic [AddrW-1:0] taddr(input logic [IdxW-1:0] j,
                                             input logic [SetW-1:0] m);
    taddr = AddrW'(j) * AddrW'(SetCount) + AddrW'(m);
  endfunction
endpackage
`default_nettype wire

@@ sv/window_path_held_karp_reorder_unit.sv @@
`default_nettype none
// One window is handled at a time; requests stall during the solve and while
// the n results drain at up to one per cycle.
// The DP tables, one read and one write per cycle, set the solve time.
// Synchronous active-low reset returns to loading with count zero, size 8.
// ----------------------------------------------------------------------------
// window_path_held_karp_reorder_unit
// Reorders one window of a tour by exact bitmask dynamic programming.
// ----------------------------------------------------------------------------
module window_path_held_karp_reorder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,  // window_size
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // city_id[9:0], x_coord[22:10], y_coord[35:23]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // placed_id[9:0], path_cost[40:10]
  output logic             out_tlast   // last_slot
);
  import whkr_pkg::*;

  logic [3:0] win_r;
  logic st_we;
  logic [3:0] st_addr;
  cmd_t cmd;
  logic [9:0] pid;
  logic [CostW-1:0] tot;

  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= 4'd8;
    else if (cfg_we) win_r <= cfg_wdata;
  end

  whkr_ctrl u_ctrl (
    .clk, .rst_n, .win_size(win_r), .in_fire(in_tvalid & in_tready),
    .in_ready(in_tready), .st_we, .st_addr, .cmd,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_last(out_tlast)
  );

  whkr_datapath u_dp (
    .clk, .st_we, .st_addr, .st_data(in_tdata[35:0]), .cmd,
    .placed_id(pid), .total(tot)
  );

  assign out_tdata = {7'd0, tot, pid};

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("load during output");
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> out_tvalid) else $error("tlast without valid");
  a_back_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("no return to load");
`endif
endmodule
`default_nettype wire

@@ sv/whkr_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// whkr_datapath
// City store, DP tables, edge cost unit and result order register.
// ----------------------------------------------------------------------------
module whkr_datapath (
  input  wire logic                     clk,
  input  wire logic                     st_we,
  input  wire logic [3:0]               st_addr,
  input  wire logic [35:0]              st_data,
  input  wire whkr_pkg::cmd_t           cmd,
  output logic [9:0]                    placed_id,
  output logic [whkr_pkg::CostW-1:0]    total
);
  import whkr_pkg::*;

  logic [35:0] city_r [StoreDepth];
  logic [CostW-1:0] cost_mem [TableDepth];
  logic [IdxW-1:0]  pred_mem [TableDepth];
  logic [CostW-1:0] rd_cost_r;
  logic [IdxW-1:0]  rd_pred_r;
  logic [CostW-1:0] src_r, edge_r, cand_r, total_r;
  logic [IdxW-1:0]  order_r [MaxWindow];
  logic [IdxW-1:0]  cur_r;
  logic [SetW-1:0]  bm_r;
  logic [3:0] ea, eb;
  logic [12:0] dx, dy;
  logic [26:0] dd;
  logic [CostW:0] sum;
  logic [CostW-1:0] cand;
  logic [AddrW-1:0] raddr, waddr;
  logic we;
  logic [CostW-1:0] wcost;
  logic [IdxW-1:0] wpred;

  always_ff @(posedge clk) begin
    if (st_we) city_r[st_addr] <= st_data;
  end

  // edge endpoints: store slots
  always_comb begin
    ea = cmd.j + 4'd1;
    eb = cmd.k + 4'd1;
    if (cmd.do_seed) begin
      ea = 4'd0;
      eb = cmd.j + 4'd1;
    end else if (cmd.fin_edge) begin
      eb = cmd.n + 4'd1;
    end
    dx = (city_r[ea][22:10] > city_r[eb][22:10]) ? city_r[ea][22:10] - city_r[eb][22:10]
                                                 : city_r[eb][22:10] - city_r[ea][22:10];
    dy = (city_r[ea][35:23] > city_r[eb][35:23]) ? city_r[ea][35:23] - city_r[eb][35:23]
                                                 : city_r[eb][35:23] - city_r[ea][35:23];
    dd = 27'(dx) * 27'(dx) + 27'(dy) * 27'(dy);
    sum = {1'b0, src_r} + {1'b0, edge_r};
    cand = (sum > {1'b0, CostInf}) ? CostInf : sum[CostW-1:0];
  end

  always_comb begin
    raddr = taddr(cmd.j, cmd.m);
    if (cmd.rd_dst) raddr = taddr(cmd.k, cmd.m | (SetW'(1) << cmd.k));
    if (cmd.fin_rd) raddr = taddr(cmd.j, cmd.full);
    if (cmd.bt_rd)  raddr = taddr(cur_r, bm_r);
    we = 1'b0;
    waddr = taddr(cmd.j, cmd.m);
    wcost = CostInf;
    wpred = cmd.j;
    if (cmd.do_init) begin
      we = 1'b1;
    end else if (cmd.do_seed) begin
      we = 1'b1;
      waddr = taddr(cmd.j, SetW'(1) << cmd.j);
      wcost = {4'd0, dd};
    end else if (cmd.wr_dst && cand_r < rd_cost_r) begin
      we = 1'b1;
      waddr = taddr(cmd.k, cmd.m | (SetW'(1) << cmd.k));
      wcost = cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cost_mem[waddr] <= wcost;
      pred_mem[waddr] <= wpred;
    end
    rd_cost_r <= cost_mem[raddr];
    rd_pred_r <= pred_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_src || cmd.fin_rd) src_r <= rd_cost_r;
    if (cmd.edge_go || cmd.fin_edge) edge_r <= {4'd0, dd};
    cand_r <= cand;
    if (cmd.clear_acc) begin
      total_r <= {CostW{1'b1}};
      cur_r <= '0;
      bm_r <= cmd.full;
    end else begin
      // first last-city always takes the lead, later ones only when cheaper
      if (cmd.fin_cmp && (cmd.j == '0 || cand < total_r)) begin
        total_r <= cand;
        cur_r <= cmd.j;
      end
      if (cmd.bt_step) begin
        order_r[cmd.slot] <= cur_r;
        bm_r <= bm_r & ~(SetW'(1) << cur_r);
        cur_r <= (rd_pred_r >= cmd.n) ? '0 : rd_pred_r;
      end
    end
  end

  assign placed_id = city_r[order_r[cmd.slot] + 4'd1][9:0];
  assign total = total_r;
endmodule
`default_nettype wire

@@ sv/whkr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// whkr_ctrl
// Load counter and sequencer of the Held-Karp solve and result stream.
// ----------------------------------------------------------------------------
module whkr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [3:0]           win_size,
  input  wire logic                 in_fire,
  output logic                      in_ready,
  output logic                      st_we,
  output logic [3:0]                st_addr,
  output whkr_pkg::cmd_t            cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_last
);
  import whkr_pkg::*;

  state_t state_r, state_nxt;
  logic [3:0] load_r, load_nxt, n_r, n_nxt, j_r, j_nxt, k_r, k_nxt, s_r, s_nxt;
  logic [SetW-1:0] m_r, m_nxt;
  logic [3:0] n_eff, pos;
  logic [SetW-1:0] full;

  always_comb begin
    n_eff = (win_size == 4'd0) ? 4'd1 : (win_size > 4'(MaxWindow)) ? 4'(MaxWindow) : win_size;
    pos = (load_r > n_eff + 4'd1) ? n_eff + 4'd1 : load_r;
    full = SetW'((11'd1 << n_r) - 11'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      load_r <= '0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      load_r <= load_nxt;
      n_r <= n_nxt;
    end
    j_r <= j_nxt;
    k_r <= k_nxt;
    m_r <= m_nxt;
    s_r <= s_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    load_nxt = load_r;
    n_nxt = n_r;
    j_nxt = j_r;
    k_nxt = k_r;
    m_nxt = m_r;
    s_nxt = s_r;
    in_ready = 1'b0;
    st_we = 1'b0;
    st_addr = pos;
    out_valid = 1'b0;
    out_last = 1'b0;
    cmd = '0;
    cmd.j = j_r;
    cmd.k = k_r;
    cmd.m = m_r;
    cmd.full = full;
    cmd.n = n_r;
    cmd.slot = s_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          st_we = 1'b1;
          if (pos < n_eff + 4'd1) begin
            load_nxt = pos + 4'd1;
          end else begin
            load_nxt = '0;
            n_nxt = n_eff;
            j_nxt = '0;
            m_nxt = '0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // fill every entry up to the full set with infinity
        cmd.do_init = 1'b1;
        if (j_r == n_r - 4'd1) begin
          j_nxt = '0;
          if (m_r == full) begin
            state_nxt = ST_SEED;
          end else begin
            m_nxt = m_r + SetW'(1);
          end
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      ST_SEED: begin
        cmd.do_seed = 1'b1;
        if (j_r == n_r - 4'd1) begin
          j_nxt = '0;
          k_nxt = '0;
          m_nxt = SetW'(1);
          state_nxt = ST_RD;
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      ST_RD: begin
        // read cost[j][m] when j in m and k outside
        if (!m_r[j_r] || m_r[k_r]) begin
          if (k_r == n_r - 4'd1) begin
            k_nxt = '0;
            if (j_r == n_r - 4'd1) begin
              j_nxt = '0;
              if (m_r == full) begin
                cmd.clear_acc = 1'b1;
                state_nxt = ST_FIN_RD;
              end else begin
                m_nxt = m_r + SetW'(1);
              end
            end else begin
              j_nxt = j_r + 4'd1;
            end
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end else begin
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.rd_src = 1'b1;
        cmd.edge_go = 1'b1;
        cmd.rd_dst = 1'b1;
        state_nxt = ST_RDT;
      end
      ST_RDT: begin
        // hold the destination read for the compare
        cmd.rd_dst = 1'b1;
        state_nxt = ST_WRT;
      end
      ST_WRT: begin
        cmd.wr_dst = 1'b1;
        state_nxt = ST_RD;
        if (k_r == n_r - 4'd1) begin
          k_nxt = '0;
          if (j_r == n_r - 4'd1) begin
            j_nxt = '0;
            if (m_r == full) begin
              cmd.clear_acc = 1'b1;
              state_nxt = ST_FIN_RD;
            end else begin
              m_nxt = m_r + SetW'(1);
            end
          end else begin
            j_nxt = j_r + 4'd1;
          end
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      ST_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt = ST_FIN_ED;
      end
      ST_FIN_ED: begin
        cmd.fin_rd = 1'b1;
        cmd.fin_edge = 1'b1;
        state_nxt = ST_FIN_CMP;
      end
      ST_FIN_CMP: begin
        cmd.fin_cmp = 1'b1;
        if (j_r == n_r - 4'd1) begin
          s_nxt = n_r - 4'd1;
          state_nxt = ST_BT_RD;
        end else begin
          j_nxt = j_r + 4'd1;
          state_nxt = ST_FIN_RD;
        end
      end
      ST_BT_RD: begin
        cmd.bt_rd = 1'b1;
        state_nxt = ST_BT_WT;
      end
      ST_BT_WT: begin
        cmd.bt_step = 1'b1;
        if (s_r == 4'd0) begin
          state_nxt = ST_OUT;
        end else begin
          s_nxt = s_r - 4'd1;
          state_nxt = ST_BT_RD;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        out_last = (s_r == n_r - 4'd1);
        if (out_ready) begin
          if (out_last) begin
            state_nxt = ST_LOAD;
          end else begin
            s_nxt = s_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

@@ test/window_path_held_karp_reorder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// window_path_held_karp_reorder_unit_tb
// Loads windows of cities (predecessor, window cities, successor) under
// several window sizes. A local bitmask DP predicts the reordered ids and the
// path cost, and each result is checked against it in order. The sender
// works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module window_path_held_karp_reorder_unit_tb;
  import whkr_pkg::*;

  localparam int IdleLimit = 2000000;

  typedef struct {
    logic [9:0]  city_id;
    logic [12:0] x_coord;
    logic [12:0] y_coord;
  } city_t;

  typedef struct {
    logic [9:0]       placed_id;
    logic [CostW-1:0] path_cost;
    logic             last_slot;
  } slot_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  window_path_held_karp_reorder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  city_t       city_q[$];
  slot_t       placed_q[$];
  int          errors;
  int          idle_cycles;
  bit          took;
  int          burst_left;
  int          gap_left;
  int          run_left;
  int          stall_left;

  // local copy of the block state
  logic [3:0]  size_reg;
  int unsigned load_cnt;
  city_t       stored[StoreDepth];
  int unsigned dp_cost[MaxWindow][SetCount];
  int unsigned dp_from[MaxWindow][SetCount];

  function automatic int unsigned sat_sum(input longint unsigned a, input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
  endfunction

  function automatic int unsigned dist_sq(input int a, input int b);
    longint unsigned dx, dy;
    dx = (stored[a].x_coord > stored[b].x_coord) ? stored[a].x_coord - stored[b].x_coord
                                                  : stored[b].x_coord - stored[a].x_coord;
    dy = (stored[a].y_coord > stored[b].y_coord) ? stored[a].y_coord - stored[b].y_coord
                                                  : stored[b].y_coord - stored[a].y_coord;
    return sat_sum(dx * dx, dy * dy);
  endfunction

  function automatic void predict_reorder(input city_t c);
    int unsigned n, pos, full, best, total, cur, prev, cst, nm;
    int unsigned order[MaxWindow];
    slot_t r;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > MaxWindow) n = MaxWindow;
    pos = (load_cnt > n + 1) ? n + 1 : load_cnt;
    stored[pos] = c;
    if (pos < n + 1) begin
      load_cnt = pos + 1;
      return;
    end
    load_cnt = 0;
    full = (1 << n) - 1;
    for (int j = 0; j < n; j++) begin
      for (int m = 0; m <= full; m++) begin
        dp_cost[j][m] = 32'h7FFF_FFFF;
        dp_from[j][m] = j;
      end
    end
    for (int j = 0; j < n; j++) dp_cost[j][1 << j] = dist_sq(0, j + 1);
    for (int m = 1; m <= full; m++) begin
      for (int j = 0; j < n; j++) begin
        if (m[j]) begin
          for (int k = 0; k < n; k++) begin
            if (!m[k]) begin
              nm = m | (1 << k);
              cst = sat_sum(dp_cost[j][m], dist_sq(j + 1, k + 1));
              if (cst < dp_cost[k][nm]) begin
                dp_cost[k][nm] = cst;
                dp_from[k][nm] = j;
              end
            end
          end
        end
      end
    end
    best = 0;
    total = 32'hFFFF_FFFF;
    for (int j = 0; j < n; j++) begin
      cst = sat_sum(dp_cost[j][full], dist_sq(j + 1, n + 1));
      if (cst < total) begin
        total = cst;
        best = j;
      end
    end
    // walk the predecessor links back from the best last city
    cur = best;
    nm = full;
    for (int s = n; s > 0; s--) begin
      if (cur >= n) cur = 0;
      order[s - 1] = cur;
      prev = dp_from[cur][nm];
      nm = nm & ~(1 << cur);
      cur = prev;
    end
    for (int s = 0; s < n; s++) begin
      r.placed_id = stored[order[s] + 1].city_id;
      r.path_cost = total[CostW-1:0];
      r.last_slot = (s == n - 1);
      placed_q = {placed_q, r};
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts with random gaps, hold a request until taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || took)) begin
      took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (city_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {4'd0, city_q[0].y_coord, city_q[0].x_coord, city_q[0].city_id};
        if (burst_left == 0) burst_left = $urandom_range(1, 10);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stretches of full readiness and stretches of random stalls
  always @(negedge clk) begin
    if (run_left > 0) begin
      run_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= ($urandom_range(0, 2) == 0);
    end else if ($urandom_range(0, 1) == 0) begin
      run_left = $urandom_range(1, 20);
      out_tready <= 1'b1;
    end else begin
      stall_left = $urandom_range(1, 12);
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    slot_t got;
    slot_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_reorder(city_q[0]);
        void'(city_q.pop_front());
        took = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.placed_id = out_tdata[9:0];
        got.path_cost = out_tdata[40:10];
        got.last_slot = out_tlast;
        if (placed_q.size() == 0) begin
          $display("%0t: unexpected result id=%0d cost=%0d last=%0b", $time,
                   got.placed_id, got.path_cost, got.last_slot);
          errors++;
        end else begin
          want = placed_q.pop_front();
          if (got.placed_id !== want.placed_id) begin
            $display("%0t: placed_id expected %0d actual %0d", $time, want.placed_id,
                     got.placed_id);
            errors++;
          end
          if (got.path_cost !== want.path_cost) begin
            $display("%0t: path_cost expected %0d actual %0d", $time, want.path_cost,
                     got.path_cost);
            errors++;
          end
          if (got.last_slot !== want.last_slot) begin
            $display("%0t: last_slot expected %0b actual %0b", $time, want.last_slot,
                     got.last_slot);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[window_path_held_karp_reorder_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [12:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd8191;
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic queue_city(input logic [9:0] id, input logic [12:0] x, input logic [12:0] y);
    city_t c;
    c.city_id = id;
    c.x_coord = x;
    c.y_coord = y;
    city_q = {city_q, c};
  endtask

  task automatic queue_random_cities(input int count);
    for (int i = 0; i < count; i++)
      queue_city(10'($urandom_range(0, 1023)), pick_coord(), pick_coord());
  endtask

  task automatic drain();
    wait (city_q.size() == 0 && !in_tvalid && placed_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_size(input logic [3:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    size_reg = v;
  endtask

  initial begin
    int sent;
    int n;
    int extra;
    errors = 0; idle_cycles = 0; took = 1'b0;
    burst_left = 0; gap_left = 0; run_left = 0; stall_left = 0;
    size_reg = 4'd8; load_cnt = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 4'd0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset size of eight, corner ids and coordinates
    queue_city(10'd0, 13'd0, 13'd0);
    for (int i = 0; i < 8; i++)
      queue_city(10'(1023 - i), (i[0]) ? 13'd8191 : 13'd0, 13'(i * 1000));
    queue_city(10'd1023, 13'd8191, 13'd8191);
    drain();

    // zero acts as a window of one
    write_size(4'd0);
    queue_city(10'd5, 13'd8191, 13'd0);
    queue_city(10'd682, 13'd0, 13'd8191);
    queue_city(10'd341, 13'd8191, 13'd8191);
    drain();

    // above the maximum acts as the maximum; equal points force ties
    write_size(4'd15);
    queue_city(10'd1, 13'd100, 13'd100);
    for (int i = 0; i < MaxWindow; i++)
      queue_city(10'(100 + i), (i < 4) ? 13'd4000 : pick_coord(),
                 (i < 4) ? 13'd4000 : pick_coord());
    queue_city(10'd2, 13'd8191, 13'd0);
    drain();

    // lower the size in mid-load: the next request closes the window
    write_size(4'd6);
    queue_random_cities(5);
    drain();
    write_size(4'd2);
    queue_random_cities(1);
    drain();

    write_size(4'd1);
    queue_random_cities(6);
    drain();

    sent = 0;
    while (sent < 60) begin
      n = $urandom_range(1, 6);
      write_size(4'(n));
      for (int w = $urandom_range(1, 3); w > 0; w--) begin
        queue_random_cities(n + 2);
        sent += n + 2;
      end
      // leave a partial window now and then so the next size cuts it short
      if ($urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, n + 1);
        queue_random_cities(extra);
        sent += extra;
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("[window_path_held_karp_reorder_unit] OK");
    end else begin
      $display("[window_path_held_karp_reorder_unit] ERROR");
    end
    $finish;
  end
endmodule
